/* sv/aad_pkg.sv */
`default_nettype none
package aad_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W = 16;
	localparam int PEAK_W = SAMPLE_BITS;
	localparam int PEAK_OUT_W = 16;
	localparam int MARGIN_W = 16;
	localparam int HOLD_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int FALL_SHIFT = 5;
	localparam int RISE_SHIFT = 11;
	localparam int LIMIT_SHIFT = 2;
	localparam int FALL_W = PEAK_W + FALL_SHIFT;
	localparam int LIMIT_W = ((PEAK_W > MARGIN_W) ? PEAK_W : MARGIN_W) + 2;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(12000);
	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARGIN_ADD  = 2'd0,
		REG_HOLD_BLOCKS = 2'd1,
		REG_ACTIVE_LOW  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin_add;
		logic [HOLD_W-1:0]   hold_blocks;
	} floor_cfg_t;

endpackage
`default_nettype wire

/* sv/aad_if.sv */
`default_nettype none
interface aad_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [aad_pkg::SAMPLE_W-1:0]   sample;
	logic                                  last_in_block;

	modport source (output valid, output sample, output last_in_block, input ready);
	modport sink (input valid, input sample, input last_in_block, output ready);
endinterface

interface aad_out_if;
	logic                            valid;
	logic                            ready;
	logic                            led_pin;
	logic                            active;
	logic [aad_pkg::PEAK_OUT_W-1:0]  block_peak_out;

	modport source (output valid, output led_pin, output active, output block_peak_out,
		input ready);
	modport sink (input valid, input led_pin, input active, input block_peak_out,
		output ready);
endinterface

interface aad_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [aad_pkg::CFG_IDX_W-1:0]   index;
	logic [aad_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/aad_floor.sv */
`default_nettype none
module aad_floor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         upd,
	input  wire logic [aad_pkg::PEAK_W-1:0]   peak,
	input  wire aad_pkg::floor_cfg_t          cfg,
	output logic                              on
);
	import aad_pkg::*;

	logic [PEAK_W-1:0]  floor_q;
	logic               ready_q;
	logic [HOLD_W-1:0]  hold_q;

	logic [FALL_W-1:0]  fall_sum;
	logic [PEAK_W-1:0]  floor_fall;
	logic [PEAK_W-1:0]  floor_rise;
	logic [PEAK_W-1:0]  floor_next;
	logic [LIMIT_W-1:0] limit;
	logic               hit;
	logic [HOLD_W-1:0]  hold_next;

	always_comb begin
		fall_sum   = (FALL_W'(floor_q) << FALL_SHIFT) - FALL_W'(floor_q) + FALL_W'(peak);
		floor_fall = PEAK_W'(fall_sum >> FALL_SHIFT);
		floor_rise = floor_q + ((peak - floor_q) >> RISE_SHIFT);
		priority if (!ready_q) begin
			floor_next = (peak == '0) ? PEAK_W'(1) : peak;
		end else if (peak < floor_q) begin
			floor_next = floor_fall;
		end else begin
			floor_next = floor_rise;
		end
		limit = LIMIT_W'(floor_next) + LIMIT_W'(cfg.margin_add)
			+ LIMIT_W'(floor_next >> LIMIT_SHIFT);
		hit = LIMIT_W'(peak) > limit;
		priority if (hit) begin
			hold_next = cfg.hold_blocks;
		end else if (hold_q != '0) begin
			hold_next = hold_q - HOLD_W'(1);
		end else begin
			hold_next = '0;
		end
		on = hold_next != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= '0;
			ready_q <= 1'b0;
			hold_q  <= '0;
		end else if (upd) begin
			floor_q <= floor_next;
			ready_q <= 1'b1;
			hold_q  <= hold_next;
		end
	end

endmodule
`default_nettype wire

/* sv/audio_activity_detector.sv */
`default_nettype none
// Audio activity detector. Takes one signed PCM sample per word on samples and
// tracks the peak magnitude of the current block; the word flagged last_in_block
// closes the block, updates the adaptive quiet floor and the hold counter, and
// produces one result word (led_pin, active, block_peak_out). Other words give no
// result. Throughput is one sample per clock unless a block end meets a stalled
// sink; a sample passes an input register and its result appears on results the
// cycle after it leaves that register, held in an output register so a stalled
// sink does not stop the input side until a second block end arrives. Registers:
// 0 margin_add (reset 12000), 1 hold_blocks (reset 4), 2 active_low (reset 0);
// other indexes are ignored. Write them only while no block end is in flight.
module audio_activity_detector (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aad_in_if.sink     samples,
	aad_out_if.source  results,
	aad_cfg_if.sink    cfg
);
	import aad_pkg::*;

	logic [MARGIN_W-1:0]  margin_q;
	logic [HOLD_W-1:0]    hold_blocks_q;
	logic                 active_low_q;

	logic                 valid_s1;
	logic [PEAK_W-1:0]    raw_s1;
	logic                 last_s1;

	logic [PEAK_W-1:0]    run_peak_q;
	logic [PEAK_W-1:0]    mag;
	logic [PEAK_W-1:0]    peak_cur;
	logic                 advance;
	logic                 close;
	logic                 on;
	floor_cfg_t           floor_cfg;

	logic                 out_valid_q;
	logic                 led_q;
	logic                 active_q;
	logic [PEAK_OUT_W-1:0] peak_out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q      <= MARGIN_RESET;
			hold_blocks_q <= HOLD_RESET;
			active_low_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MARGIN_ADD:  margin_q      <= MARGIN_W'(cfg.data);
				REG_HOLD_BLOCKS: hold_blocks_q <= HOLD_W'(cfg.data);
				REG_ACTIVE_LOW:  active_low_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mag      = raw_s1[PEAK_W-1] ? (~raw_s1 + PEAK_W'(1)) : raw_s1;
		peak_cur = (mag > run_peak_q) ? mag : run_peak_q;
		advance  = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
		close    = advance && last_s1;
		floor_cfg.margin_add  = margin_q;
		floor_cfg.hold_blocks = hold_blocks_q;
	end

	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			raw_s1  <= samples.sample[PEAK_W-1:0];
			last_s1 <= samples.last_in_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_peak_q <= '0;
		end else if (advance) begin
			run_peak_q <= last_s1 ? '0 : peak_cur;
		end
	end

	aad_floor u_floor (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (close),
		.peak   (peak_cur),
		.cfg    (floor_cfg),
		.on     (on)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (close) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			led_q      <= on ^ active_low_q;
			active_q   <= on;
			peak_out_q <= PEAK_OUT_W'(peak_cur);
		end
	end

	assign results.valid          = out_valid_q;
	assign results.led_pin        = led_q;
	assign results.active         = active_q;
	assign results.block_peak_out = peak_out_q;

endmodule
`default_nettype wire
